/* sv/bcs_pkg.sv */
`timescale 1ns / 1ps
// bcs_pkg: shared types and constants for the beacon clock synchronizer
// no dependencies

package bcs_pkg;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam int OUT_TIME_BITS = 32;

    localparam logic [CFG_IDX_BITS-1:0] REG_SEND_INTERVAL    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_PEER_TIMEOUT     = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_OWN_GROUP_ID     = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_RESYNC_THRESHOLD = 2'd3;

    localparam logic [15:0] SEND_INTERVAL_RST    = 16'd3000;
    localparam logic [15:0] PEER_TIMEOUT_RST     = 16'd5000;
    localparam logic [7:0]  OWN_GROUP_ID_RST     = 8'd0;
    localparam logic [15:0] RESYNC_THRESHOLD_RST = 16'd50;

    localparam logic KIND_TICK   = 1'b0;
    localparam logic KIND_BEACON = 1'b1;

    typedef struct packed {
        logic [15:0] send_interval;
        logic [15:0] peer_timeout;
        logic [7:0]  own_group_id;
        logic [15:0] resync_threshold;
    } cfg_t;

    typedef struct packed {
        logic                     send_beacon;
        logic [OUT_TIME_BITS-1:0] tx_time;
        logic                     peer_present;
        logic                     peer_found;
        logic                     peer_lost;
        logic [OUT_TIME_BITS-1:0] clock_now;
    } result_t;

endpackage

/* sv/bcs_step.sv */
`timescale 1ns / 1ps
// bcs_step: next-state and result logic for one tick or beacon
// depends on bcs_pkg

module bcs_step #(
    parameter int TIME_BITS = 32
) (
    input  logic                 kind,
    input  logic [31:0]          rx_time,
    input  logic [7:0]           rx_group_id,
    input  bcs_pkg::cfg_t        cfg,
    input  logic [TIME_BITS-1:0] uptime,
    input  logic [TIME_BITS-1:0] shared_clock,
    input  logic [TIME_BITS-1:0] last_sent,
    input  logic [TIME_BITS-1:0] last_seen,
    input  logic                 peer_flag,
    input  logic                 quick_pending,
    output logic [TIME_BITS-1:0] uptime_next,
    output logic [TIME_BITS-1:0] shared_clock_next,
    output logic [TIME_BITS-1:0] last_sent_next,
    output logic [TIME_BITS-1:0] last_seen_next,
    output logic                 peer_flag_next,
    output logic                 quick_pending_next,
    output bcs_pkg::result_t     result
);

    localparam int W = (TIME_BITS > bcs_pkg::OUT_TIME_BITS) ? TIME_BITS
                                                            : bcs_pkg::OUT_TIME_BITS;

    logic [TIME_BITS-1:0] up_inc;
    logic [TIME_BITS-1:0] clk_inc;
    logic [TIME_BITS-1:0] interval_t;
    logic [TIME_BITS-1:0] timeout_t;
    logic [TIME_BITS-1:0] thresh_t;
    logic [TIME_BITS-1:0] rt;
    logic [TIME_BITS-1:0] diff;
    logic [TIME_BITS:0]   avg_sum;
    logic [W-1:0]         rx_wide;
    logic [W-1:0]         clk_wide;
    logic [W-1:0]         tx_wide;
    logic                 periodic;
    logic                 send;
    logic                 lost;
    logic                 sender_ok;
    logic                 found;

    assign interval_t = TIME_BITS'(cfg.send_interval);
    assign timeout_t  = TIME_BITS'(cfg.peer_timeout);
    assign thresh_t   = TIME_BITS'(cfg.resync_threshold);

    // tick path
    assign up_inc   = uptime + TIME_BITS'(1);
    assign clk_inc  = shared_clock + TIME_BITS'(1);
    assign periodic = (up_inc > interval_t) && ((up_inc - last_sent) >= interval_t);
    assign send     = quick_pending || periodic;
    assign lost     = peer_flag && ((up_inc - last_seen) > timeout_t);

    // beacon path
    assign rx_wide   = W'(rx_time);
    assign rt        = rx_wide[TIME_BITS-1:0];
    assign sender_ok = (cfg.own_group_id == 8'd0) || (rx_group_id != cfg.own_group_id);
    assign found     = sender_ok && !peer_flag;
    assign diff      = (shared_clock >= rt) ? (shared_clock - rt) : (rt - shared_clock);
    assign avg_sum   = {1'b0, shared_clock} + {1'b0, rt};

    always_comb begin
        uptime_next        = uptime;
        shared_clock_next  = shared_clock;
        last_sent_next     = last_sent;
        last_seen_next     = last_seen;
        peer_flag_next     = peer_flag;
        quick_pending_next = quick_pending;
        tx_wide            = '0;
        result             = '0;
        if (kind == bcs_pkg::KIND_TICK) begin
            uptime_next        = up_inc;
            shared_clock_next  = clk_inc;
            quick_pending_next = 1'b0;
            if (!quick_pending && periodic) begin
                last_sent_next = up_inc;
            end
            if (lost) begin
                peer_flag_next = 1'b0;
            end
            if (send) begin
                tx_wide = W'(clk_inc);
            end
            result.send_beacon = send;
            result.tx_time     = tx_wide[bcs_pkg::OUT_TIME_BITS-1:0];
            result.peer_lost   = lost;
        end else begin
            if (sender_ok) begin
                last_seen_next = uptime;
                peer_flag_next = 1'b1;
            end
            quick_pending_next = quick_pending || found || (diff > thresh_t);
            shared_clock_next  = avg_sum[TIME_BITS:1];
            result.peer_found  = found;
        end
        clk_wide            = W'(shared_clock_next);
        result.peer_present = peer_flag_next;
        result.clock_now    = clk_wide[bcs_pkg::OUT_TIME_BITS-1:0];
    end

endmodule

/* sv/beacon_clock_sync.sv */
`timescale 1ns / 1ps
// beacon_clock_sync: peer clock synchronizer top level
// depends on bcs_pkg and bcs_step

// One result beat per input beat, one beat per clock sustained while m_ready
// stays high. Each beat is captured in an input register, then the tick or
// beacon update (adds, subtracts and compares) runs combinationally into the
// result register. Input and result registers let a new beat enter while the
// previous result waits on m_ready. Config writes are taken at any time but
// must only be issued while the block is idle.
module beacon_clock_sync #(
    parameter int TIME_BITS = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [bcs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [bcs_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_kind,
    input  logic [31:0]                       s_rx_time,
    input  logic [7:0]                        s_rx_group_id,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_send_beacon,
    output logic [31:0]                       m_tx_time,
    output logic                              m_peer_present,
    output logic                              m_peer_found,
    output logic                              m_peer_lost,
    output logic [31:0]                       m_clock_now
);

    bcs_pkg::cfg_t        cfg_reg;
    logic                 in_valid_reg;
    logic                 in_kind_reg;
    logic [31:0]          in_rx_time_reg;
    logic [7:0]           in_group_reg;
    logic                 out_valid_reg;
    bcs_pkg::result_t     result_reg;
    bcs_pkg::result_t     result_next;

    logic [TIME_BITS-1:0] uptime_reg;
    logic [TIME_BITS-1:0] shared_clock_reg;
    logic [TIME_BITS-1:0] last_sent_reg;
    logic [TIME_BITS-1:0] last_seen_reg;
    logic                 peer_flag_reg;
    logic                 quick_pending_reg;
    logic [TIME_BITS-1:0] uptime_next;
    logic [TIME_BITS-1:0] shared_clock_next;
    logic [TIME_BITS-1:0] last_sent_next;
    logic [TIME_BITS-1:0] last_seen_next;
    logic                 peer_flag_next;
    logic                 quick_pending_next;

    logic advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    bcs_step #(
        .TIME_BITS(TIME_BITS)
    ) u_step (
        .kind               (in_kind_reg),
        .rx_time            (in_rx_time_reg),
        .rx_group_id        (in_group_reg),
        .cfg                (cfg_reg),
        .uptime             (uptime_reg),
        .shared_clock       (shared_clock_reg),
        .last_sent          (last_sent_reg),
        .last_seen          (last_seen_reg),
        .peer_flag          (peer_flag_reg),
        .quick_pending      (quick_pending_reg),
        .uptime_next        (uptime_next),
        .shared_clock_next  (shared_clock_next),
        .last_sent_next     (last_sent_next),
        .last_seen_next     (last_seen_next),
        .peer_flag_next     (peer_flag_next),
        .quick_pending_next (quick_pending_next),
        .result             (result_next)
    );

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.send_interval    <= bcs_pkg::SEND_INTERVAL_RST;
            cfg_reg.peer_timeout     <= bcs_pkg::PEER_TIMEOUT_RST;
            cfg_reg.own_group_id     <= bcs_pkg::OWN_GROUP_ID_RST;
            cfg_reg.resync_threshold <= bcs_pkg::RESYNC_THRESHOLD_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                bcs_pkg::REG_SEND_INTERVAL:    cfg_reg.send_interval    <= cfg_wdata;
                bcs_pkg::REG_PEER_TIMEOUT:     cfg_reg.peer_timeout     <= cfg_wdata;
                bcs_pkg::REG_OWN_GROUP_ID:     cfg_reg.own_group_id     <= cfg_wdata[7:0];
                bcs_pkg::REG_RESYNC_THRESHOLD: cfg_reg.resync_threshold <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_kind_reg    <= s_kind;
            in_rx_time_reg <= s_rx_time;
            in_group_reg   <= s_rx_group_id;
        end
    end

    // synchronizer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            uptime_reg        <= '0;
            shared_clock_reg  <= '0;
            last_sent_reg     <= '0;
            last_seen_reg     <= '0;
            peer_flag_reg     <= 1'b0;
            quick_pending_reg <= 1'b0;
        end else if (advance) begin
            uptime_reg        <= uptime_next;
            shared_clock_reg  <= shared_clock_next;
            last_sent_reg     <= last_sent_next;
            last_seen_reg     <= last_seen_next;
            peer_flag_reg     <= peer_flag_next;
            quick_pending_reg <= quick_pending_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_send_beacon  = result_reg.send_beacon;
    assign m_tx_time      = result_reg.tx_time;
    assign m_peer_present = result_reg.peer_present;
    assign m_peer_found   = result_reg.peer_found;
    assign m_peer_lost    = result_reg.peer_lost;
    assign m_clock_now    = result_reg.clock_now;

    a_found_lost_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_peer_found && m_peer_lost))
        else $error("peer found and lost in one beat");

    a_tx_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_send_beacon |-> m_tx_time == 32'd0)
        else $error("tx_time nonzero without beacon");

    a_found_present: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_peer_found |-> m_peer_present)
        else $error("new peer not marked present");

    a_lost_absent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_peer_lost |-> !m_peer_present)
        else $error("lost peer still marked present");

    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(uptime_reg) && $stable(peer_flag_reg))
        else $error("state changed without a processed beat");

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// testbench: self-checking random test of beacon_clock_sync with a built-in model
// depends on bcs_pkg and the beacon_clock_sync rtl

module testbench;
    import bcs_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_BEATS = 1400;
    localparam int PHASES       = 6;
    localparam int HOLD_AFTER   = 400;
    localparam int HOLD_CYCLES  = 300;

    class sync_tracker;
        logic [15:0] send_interval;
        logic [15:0] peer_timeout;
        logic [7:0]  own_group_id;
        logic [15:0] resync_threshold;
        logic [31:0] uptime;
        logic [31:0] shared_clock;
        logic [31:0] last_sent;
        logic [31:0] last_seen;
        logic        peer_flag;
        logic        quick_pending;
        result_t     sync_reports_q[$];
        int          mismatches;

        function new();
            send_interval    = SEND_INTERVAL_RST;
            peer_timeout     = PEER_TIMEOUT_RST;
            own_group_id     = OWN_GROUP_ID_RST;
            resync_threshold = RESYNC_THRESHOLD_RST;
            uptime           = '0;
            shared_clock     = '0;
            last_sent        = '0;
            last_seen        = '0;
            peer_flag        = 1'b0;
            quick_pending    = 1'b0;
            mismatches       = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                REG_SEND_INTERVAL:    send_interval = data;
                REG_PEER_TIMEOUT:     peer_timeout = data;
                REG_OWN_GROUP_ID:     own_group_id = data[7:0];
                REG_RESYNC_THRESHOLD: resync_threshold = data;
                default: ;
            endcase
        endfunction

        function void note_beat(logic kind, logic [31:0] rx_time, logic [7:0] gid);
            result_t     r;
            logic [31:0] elapsed;
            logic [31:0] diff;
            r = '0;
            if (kind == KIND_TICK) begin
                uptime       = uptime + 32'd1;
                shared_clock = shared_clock + 32'd1;
                elapsed      = uptime - last_sent;
                if (quick_pending) begin
                    r.send_beacon = 1'b1;
                    quick_pending = 1'b0;
                end else if (uptime > 32'(send_interval) && elapsed >= 32'(send_interval)) begin
                    last_sent     = uptime;
                    r.send_beacon = 1'b1;
                end
                if (r.send_beacon)
                    r.tx_time = shared_clock;
                elapsed = uptime - last_seen;
                if (peer_flag && elapsed > 32'(peer_timeout)) begin
                    peer_flag   = 1'b0;
                    r.peer_lost = 1'b1;
                end
            end else begin
                if (own_group_id == 8'd0 || gid != own_group_id) begin
                    last_seen = uptime;
                    if (!peer_flag) begin
                        peer_flag     = 1'b1;
                        r.peer_found  = 1'b1;
                        quick_pending = 1'b1;
                    end
                end
                diff = (shared_clock >= rx_time) ? shared_clock - rx_time
                                                 : rx_time - shared_clock;
                if (diff > 32'(resync_threshold))
                    quick_pending = 1'b1;
                shared_clock = (shared_clock >> 1) + (rx_time >> 1)
                             + {31'd0, shared_clock[0] & rx_time[0]};
            end
            r.peer_present = peer_flag;
            r.clock_now    = shared_clock;
            sync_reports_q.push_back(r);
        endfunction

        function void check_beat(result_t got);
            result_t want;
            if (sync_reports_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: send=%0d tx=%h present=%0d found=%0d lost=%0d clock=%h",
                             got.send_beacon, got.tx_time, got.peer_present,
                             got.peer_found, got.peer_lost, got.clock_now);
            end else begin
                want = sync_reports_q.pop_front();
                if (got.send_beacon !== want.send_beacon || got.tx_time !== want.tx_time ||
                    got.peer_present !== want.peer_present ||
                    got.peer_found !== want.peer_found || got.peer_lost !== want.peer_lost ||
                    got.clock_now !== want.clock_now) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch expected: send=%0d tx=%h present=%0d found=%0d lost=%0d clock=%h",
                                 want.send_beacon, want.tx_time, want.peer_present,
                                 want.peer_found, want.peer_lost, want.clock_now);
                        $display("         actual:   send=%0d tx=%h present=%0d found=%0d lost=%0d clock=%h",
                                 got.send_beacon, got.tx_time, got.peer_present,
                                 got.peer_found, got.peer_lost, got.clock_now);
                    end
                end
            end
        endfunction
    endclass

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_wdata;
    logic                     s_valid;
    logic                     s_ready;
    logic                     s_kind;
    logic [31:0]              s_rx_time;
    logic [7:0]               s_rx_group_id;
    logic                     m_valid;
    logic                     m_ready;
    logic                     m_send_beacon;
    logic [31:0]              m_tx_time;
    logic                     m_peer_present;
    logic                     m_peer_found;
    logic                     m_peer_lost;
    logic [31:0]              m_clock_now;

    sync_tracker sb;
    int          results_seen = 0;

    always #6 aclk = ~aclk;

    beacon_clock_sync dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_rx_time      (s_rx_time),
        .s_rx_group_id  (s_rx_group_id),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_send_beacon  (m_send_beacon),
        .m_tx_time      (m_tx_time),
        .m_peer_present (m_peer_present),
        .m_peer_found   (m_peer_found),
        .m_peer_lost    (m_peer_lost),
        .m_clock_now    (m_clock_now)
    );

    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            pick_idle = 0;
        else if (r < 90)
            pick_idle = $urandom_range(1, 3);
        else if (r < 98)
            pick_idle = $urandom_range(4, 10);
        else
            pick_idle = $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] pick_rx_time();
        logic [31:0] offset;
        int          r;
        r      = $urandom_range(0, 99);
        offset = 32'(sb.resync_threshold) + 32'($urandom_range(0, 6)) - 32'd3;
        if (r < 20)
            pick_rx_time = sb.shared_clock;
        else if (r < 40)
            pick_rx_time = sb.shared_clock + offset;
        else if (r < 60)
            pick_rx_time = sb.shared_clock - offset;
        else
            pick_rx_time = $urandom;
    endfunction

    function automatic logic [7:0] pick_group();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            pick_group = sb.own_group_id;
        else if (r < 50)
            pick_group = 8'h00;
        else if (r < 65)
            pick_group = 8'hff;
        else
            pick_group = 8'($urandom);
    endfunction

    task automatic offer_beat(input logic kind, input logic [31:0] rx_time,
                              input logic [7:0] gid);
        int gap;
        gap = pick_idle();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_kind        <= kind;
        s_rx_time     <= rx_time;
        s_rx_group_id <= gid;
        do
            @(posedge aclk);
        while (!s_ready);
        sb.note_beat(kind, rx_time, gid);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.sync_reports_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_setting(input logic [CFG_IDX_BITS-1:0] idx,
                                 input logic [CFG_DATA_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        sb.write_reg(idx, data);
    endtask

    task automatic apply_settings(input logic [15:0] interval, input logic [15:0] timeout,
                                  input logic [7:0] group, input logic [15:0] threshold);
        write_setting(REG_SEND_INTERVAL, interval);
        write_setting(REG_PEER_TIMEOUT, timeout);
        write_setting(REG_OWN_GROUP_ID, {8'd0, group});
        write_setting(REG_RESYNC_THRESHOLD, threshold);
        cfg_we <= 1'b0;
    endtask

    // result side: random back-pressure plus one long hold-off
    initial begin : receiver
        int gap;
        bit held;
        held = 1'b0;
        m_ready <= 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (!held && results_seen >= HOLD_AFTER) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                gap = pick_idle();
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_beat({m_send_beacon, m_tx_time, m_peer_present,
                           m_peer_found, m_peer_lost, m_clock_now});
            results_seen++;
        end
    end

    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("beacon_clock_sync test failed");
        $finish;
    end

    initial begin : stimulus
        int          sent;
        int          burst;
        logic [15:0] interval;
        logic [15:0] timeout;
        logic [7:0]  group;
        logic [15:0] threshold;
        sb = new();
        aresetn       <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= REG_SEND_INTERVAL;
        cfg_wdata     <= '0;
        s_valid       <= 1'b0;
        s_kind        <= KIND_TICK;
        s_rx_time     <= '0;
        s_rx_group_id <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: new peer, quick responses, threshold edges
        offer_beat(KIND_TICK, 32'h0, 8'h00);
        offer_beat(KIND_BEACON, 32'h0, 8'h00);
        offer_beat(KIND_TICK, 32'h0, 8'h00);
        offer_beat(KIND_BEACON, 32'hffff_ffff, 8'hff);
        offer_beat(KIND_TICK, 32'h0, 8'h00);
        offer_beat(KIND_BEACON, sb.shared_clock + 32'd50, 8'h11);
        offer_beat(KIND_TICK, 32'h0, 8'h00);
        offer_beat(KIND_BEACON, sb.shared_clock - 32'd51, 8'h22);
        offer_beat(KIND_TICK, 32'h0, 8'h00);
        drain();

        // zero interval and timeout, group filter, clock wrap
        apply_settings(16'd0, 16'd0, 8'ha5, 16'd0);
        offer_beat(KIND_TICK, 32'h0, 8'h00);
        offer_beat(KIND_BEACON, sb.shared_clock, 8'ha5);
        offer_beat(KIND_BEACON, sb.shared_clock, 8'h5a);
        offer_beat(KIND_TICK, 32'h0, 8'h00);
        offer_beat(KIND_BEACON, sb.shared_clock + 32'd1, 8'h00);
        repeat (3) offer_beat(KIND_BEACON, 32'hffff_ffff, 8'h5a);
        offer_beat(KIND_TICK, 32'hffff_ffff, 8'hff);
        repeat (2) offer_beat(KIND_TICK, 32'h0, 8'h00);

        for (int p = 0; p < PHASES; p++) begin
            drain();
            if (p == 0) begin
                interval = 16'd1;
                timeout = 16'd1;
                group = 8'hff;
                threshold = 16'hffff;
            end else if (p == 1) begin
                interval = 16'hffff;
                timeout = 16'hffff;
                group = 8'h00;
                threshold = 16'd0;
            end else begin
                interval = 16'($urandom_range(0, 12));
                timeout = 16'($urandom_range(0, 30));
                group = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(1, 255));
                threshold = 16'($urandom_range(0, 300));
            end
            apply_settings(interval, timeout, group, threshold);
            sent = 0;
            while (sent < RANDOM_BEATS / PHASES) begin
                if ($urandom_range(0, 99) < 15) begin
                    burst = $urandom_range(1, (sb.peer_timeout < 50) ? sb.peer_timeout + 10 : 60);
                    repeat (burst) offer_beat(KIND_TICK, $urandom, 8'($urandom));
                    sent += burst;
                end else begin
                    if ($urandom_range(0, 99) < 60)
                        offer_beat(KIND_TICK, $urandom, 8'($urandom));
                    else
                        offer_beat(KIND_BEACON, pick_rx_time(), pick_group());
                    sent++;
                end
            end
        end

        drain();
        repeat (10) @(posedge aclk);
        if (sb.mismatches == 0 && sb.sync_reports_q.size() == 0)
            $display("beacon_clock_sync test passed");
        else
            $display("beacon_clock_sync test failed");
        $finish;
    end

endmodule
